@@ rtl/cpw_pkg.sv @@
// cpw_pkg: shared types and constants for the checkpoint loop watchdog.
// Used by cpw_regs, cpw_step and checkpoint_loop_watchdog; no dependencies.
`timescale 1ns / 1ps

package cpw_pkg;

    localparam int NUM_CHECKPOINTS = 12;
    localparam int MASK_W          = NUM_CHECKPOINTS + 1;
    localparam int ID_W            = 4;
    localparam int CODE_W          = 2;
    localparam int TIME_W          = 32;
    localparam int THR_W           = 16;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic [MASK_W-1:0] REQ_MASK_RESET = MASK_W'(2046);
    localparam logic [THR_W-1:0]  THR_RESET      = THR_W'(900);
    localparam logic [THR_W-1:0]  ELAPSED_SAT    = {THR_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_NOTE  = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_REQ_MASK  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HW_PRESENT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [MASK_W-1:0] required_mask;
        logic [THR_W-1:0]  timeout_threshold_ms;
        logic              hw_watchdog_present;
    } cfg_t;

    typedef struct packed {
        logic              kick;
        logic              timeout_flag;
        logic [ID_W-1:0]   timeout_checkpoint;
        logic [THR_W-1:0]  timeout_elapsed_ms;
        logic [TIME_W-1:0] loops_done;
        logic [TIME_W-1:0] longest_loop_ms;
        logic [ID_W-1:0]   last_checkpoint_id;
        logic [CODE_W-1:0] last_result_code;
        logic              loop_armed;
    } res_t;

endpackage

@@ rtl/checkpoint_loop_watchdog.sv @@
// checkpoint_loop_watchdog: top level, input handshake, output skid buffer.
// Depends on cpw_pkg, cpw_regs and cpw_step.
// Result words are registered: in the output register, else behind it in the skid entry.
// One word per cycle unless in_stall; the loop state update is a single registered pass.
// in_stall rises only when both the output register and the skid register hold words.
// Reset (rst_n low, asynchronous) clears all loop state and the output buffer and
// loads the register defaults (required mask 2046, threshold 900 ms, no hardware).
`timescale 1ns / 1ps

module checkpoint_loop_watchdog (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cpw_pkg::ADDR_W-1:0]    paddr,
    input  logic [cpw_pkg::DATA_W-1:0]    pwdata,
    output logic [cpw_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // command channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [cpw_pkg::ID_W-1:0]      checkpoint_id,
    input  logic [cpw_pkg::CODE_W-1:0]    result_code,
    input  logic [cpw_pkg::TIME_W-1:0]    now_ms,
    input  logic                          refresh_ok,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kick,
    output logic                          timeout_flag,
    output logic [cpw_pkg::ID_W-1:0]      timeout_checkpoint,
    output logic [cpw_pkg::THR_W-1:0]     timeout_elapsed_ms,
    output logic [cpw_pkg::TIME_W-1:0]    loops_done,
    output logic [cpw_pkg::TIME_W-1:0]    longest_loop_ms,
    output logic [cpw_pkg::ID_W-1:0]      last_checkpoint_id,
    output logic [cpw_pkg::CODE_W-1:0]    last_result_code,
    output logic                          loop_armed
);
    import cpw_pkg::*;

    cfg_t cfg;
    res_t step_res;
    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic accept;
    logic take;

    // Stall only from a register, so the input side never waits on out_stall.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take     = out_valid_reg && !out_stall;

    cpw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Loop state advances at the edge that accepts a command word.
    cpw_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .load          (accept),
        .command       (command),
        .checkpoint_id (checkpoint_id),
        .result_code   (result_code),
        .now_ms        (now_ms),
        .refresh_ok    (refresh_ok),
        .res           (step_res)
    );

    // Output register plus one skid entry: a new word goes to the output register
    // when it is free or being drained, otherwise park it in the skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (accept)
        begin
            if (out_valid_reg && !take)
                skid_reg <= step_res;
            else
                out_reg <= step_res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign kick               = out_reg.kick;
    assign timeout_flag       = out_reg.timeout_flag;
    assign timeout_checkpoint = out_reg.timeout_checkpoint;
    assign timeout_elapsed_ms = out_reg.timeout_elapsed_ms;
    assign loops_done         = out_reg.loops_done;
    assign longest_loop_ms    = out_reg.longest_loop_ms;
    assign last_checkpoint_id = out_reg.last_checkpoint_id;
    assign last_result_code   = out_reg.last_result_code;
    assign loop_armed         = out_reg.loop_armed;

    // The skid entry is only ever filled behind a held output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word with the output register empty");

    // A stalled output with a full skid entry must keep both words.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && out_valid_reg)
        else $error("buffered word dropped while stalled");

    // Hold the offered result word steady while the receiver stalls.
    a_out_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(out_reg))
        else $error("result word changed while stalled");

endmodule

@@ rtl/cpw_regs.sv @@
// cpw_regs: APB-style configuration registers of the loop watchdog.
// Depends on cpw_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module cpw_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpw_pkg::ADDR_W-1:0]   paddr,
    input  logic [cpw_pkg::DATA_W-1:0]   pwdata,
    output logic [cpw_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output cpw_pkg::cfg_t                cfg
);
    import cpw_pkg::*;

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.required_mask        <= REQ_MASK_RESET;
            cfg_reg.timeout_threshold_ms <= THR_RESET;
            cfg_reg.hw_watchdog_present  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_REQ_MASK:   cfg_reg.required_mask <= pwdata[MASK_W-1:0];
                REG_THRESHOLD:  cfg_reg.timeout_threshold_ms <= pwdata[THR_W-1:0];
                REG_HW_PRESENT: cfg_reg.hw_watchdog_present <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_REQ_MASK:   prdata = DATA_W'(cfg_reg.required_mask);
            REG_THRESHOLD:  prdata = DATA_W'(cfg_reg.timeout_threshold_ms);
            REG_HW_PRESENT: prdata = DATA_W'(cfg_reg.hw_watchdog_present);
            default:        prdata = '0;
        endcase
    end

endmodule

@@ rtl/cpw_step.sv @@
// cpw_step: loop state registers and the registered command update.
// Depends on cpw_pkg for command codes, cfg_t and res_t.
`timescale 1ns / 1ps

module cpw_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpw_pkg::cfg_t                 cfg,
    input  logic                          load,
    input  logic [1:0]                    command,
    input  logic [cpw_pkg::ID_W-1:0]      checkpoint_id,
    input  logic [cpw_pkg::CODE_W-1:0]    result_code,
    input  logic [cpw_pkg::TIME_W-1:0]    now_ms,
    input  logic                          refresh_ok,
    output cpw_pkg::res_t                 res
);
    import cpw_pkg::*;

    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic [TIME_W-1:0] max_reg, max_next;
    logic [MASK_W-1:0] seen_reg, seen_next;
    logic [ID_W-1:0]   recent_id_reg, recent_id_next;
    logic [CODE_W-1:0] recent_code_reg, recent_code_next;
    logic              armed_reg, armed_next;

    logic [TIME_W-1:0] span;
    logic              span_ok;
    logic              id_ok;
    logic              complete;
    logic              tflag;
    logic              kick;

    // Elapsed time counts only while armed and time has not gone backward.
    assign span_ok  = armed_reg && (now_ms >= start_reg);
    assign span     = span_ok ? (now_ms - start_reg) : '0;
    assign id_ok    = armed_reg && (checkpoint_id != '0)
                      && (32'(checkpoint_id) <= NUM_CHECKPOINTS);
    assign complete = (seen_reg & cfg.required_mask) == cfg.required_mask;

    always_comb
    begin
        start_next       = start_reg;
        count_next       = count_reg;
        max_next         = max_reg;
        seen_next        = seen_reg;
        recent_id_next   = recent_id_reg;
        recent_code_next = recent_code_reg;
        armed_next       = armed_reg;
        tflag            = 1'b0;
        kick             = 1'b0;
        res.timeout_checkpoint = '0;
        res.timeout_elapsed_ms = '0;

        case (command)
            CMD_BEGIN:
            begin
                start_next       = now_ms;
                seen_next        = '0;
                recent_id_next   = '0;
                recent_code_next = '0;
                armed_next       = 1'b1;
            end
            CMD_NOTE:
            begin
                if (id_ok)
                begin
                    recent_id_next   = checkpoint_id;
                    recent_code_next = result_code;
                    seen_next        = seen_reg | (MASK_W'(1) << checkpoint_id);
                    if (span > max_reg)
                        max_next = span;
                end
            end
            CMD_TICK:
            begin
                if (span > max_reg)
                    max_next = span;
                if (cfg.hw_watchdog_present && armed_reg && !complete
                    && (span > TIME_W'(cfg.timeout_threshold_ms)))
                begin
                    tflag = 1'b1;
                    res.timeout_checkpoint = recent_id_reg;
                    res.timeout_elapsed_ms = (|span[TIME_W-1:THR_W]) ? ELAPSED_SAT
                                                                     : span[THR_W-1:0];
                end
                if (refresh_ok && armed_reg && complete)
                begin
                    kick       = cfg.hw_watchdog_present;
                    count_next = count_reg + TIME_W'(1);
                    armed_next = 1'b0;
                end
            end
            default: ;
        endcase

        res.kick               = kick;
        res.timeout_flag       = tflag;
        res.loops_done         = count_next;
        res.longest_loop_ms    = max_next;
        res.last_checkpoint_id = recent_id_next;
        res.last_result_code   = recent_code_next;
        res.loop_armed         = armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg       <= '0;
            count_reg       <= '0;
            max_reg         <= '0;
            seen_reg        <= '0;
            recent_id_reg   <= '0;
            recent_code_reg <= '0;
            armed_reg       <= 1'b0;
        end
        else if (load)
        begin
            start_reg       <= start_next;
            count_reg       <= count_next;
            max_reg         <= max_next;
            seen_reg        <= seen_next;
            recent_id_reg   <= recent_id_next;
            recent_code_reg <= recent_code_next;
            armed_reg       <= armed_next;
        end
    end

    // A kick needs a complete loop, a timeout an incomplete one.
    a_kick_excl_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(res.kick && res.timeout_flag))
        else $error("kick and timeout in the same word");

    a_kick_needs_hw: assert property (@(posedge clk) disable iff (!rst_n)
        load && res.kick |-> cfg.hw_watchdog_present && command == CMD_TICK)
        else $error("kick without hardware watchdog or tick");

    a_count_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        load && command != CMD_TICK |=> count_reg == $past(count_reg))
        else $error("loop count moved on a non-tick command");

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_reg >= $past(max_reg))
        else $error("longest loop time decreased");

endmodule
